@@ hdl/s2c_pkg.sv @@
// Shared types, constants and helper functions of the spherical to Cartesian converter.
`default_nettype none
package s2c_pkg;

	localparam int RW = 32;
	localparam int AW = 16;
	localparam int VW = 33;
	localparam int ZW = 34;
	localparam int OW = 33;
	localparam int PW = 2 * VW;
	localparam int FRAC_TRIG = 30;
	localparam int SCALE_STAGES = 4;

	localparam logic signed [VW-1:0] ONE_OVER_GAIN = 33'sd652032874;
	localparam logic signed [PW-1:0] OUT_MAX = 66'sd4294967295;
	localparam logic signed [PW-1:0] ROUND_HALF = 66'sd536870912;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 flip;
	} rot_t;

	typedef struct packed {
		logic [RW-1:0] radius;
		rot_t          az;
		rot_t          el;
	} cell_data_t;

	// atan(2^-k), full turn = 2^32, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] k);
		logic signed [ZW-1:0] v;
		case (k)
			5'd0:    v = 34'sd536870912;
			5'd1:    v = 34'sd316933406;
			5'd2:    v = 34'sd167458907;
			5'd3:    v = 34'sd85004756;
			5'd4:    v = 34'sd42667331;
			5'd5:    v = 34'sd21354465;
			5'd6:    v = 34'sd10679838;
			5'd7:    v = 34'sd5340245;
			5'd8:    v = 34'sd2670163;
			5'd9:    v = 34'sd1335087;
			5'd10:   v = 34'sd667544;
			5'd11:   v = 34'sd333772;
			5'd12:   v = 34'sd166886;
			5'd13:   v = 34'sd83443;
			5'd14:   v = 34'sd41722;
			5'd15:   v = 34'sd20861;
			5'd16:   v = 34'sd10430;
			5'd17:   v = 34'sd5215;
			5'd18:   v = 34'sd2608;
			5'd19:   v = 34'sd1304;
			5'd20:   v = 34'sd652;
			5'd21:   v = 34'sd326;
			5'd22:   v = 34'sd163;
			5'd23:   v = 34'sd81;
			5'd24:   v = 34'sd41;
			5'd25:   v = 34'sd20;
			5'd26:   v = 34'sd10;
			5'd27:   v = 34'sd5;
			5'd28:   v = 34'sd3;
			5'd29:   v = 34'sd1;
			5'd30:   v = 34'sd1;
			default: v = 34'sd0;
		endcase
		return v;
	endfunction

	// fold angle into [-quarter, +quarter), note whether the result must be negated
	function automatic rot_t rot_init(input logic [AW-1:0] ang);
		logic signed [AW:0] t;
		rot_t r;
		case (ang[AW-1:AW-2])
			QUAD_1, QUAD_2: begin
				t = $signed({1'b0, ang}) - 17'sd32768;
				r.flip = 1'b1;
			end
			QUAD_3: begin
				t = $signed({1'b1, ang});
				r.flip = 1'b0;
			end
			default: begin
				t = $signed({1'b0, ang});
				r.flip = 1'b0;
			end
		endcase
		r.x = ONE_OVER_GAIN;
		r.y = '0;
		r.z = {t[AW], t, 16'b0};
		return r;
	endfunction

	// Q20.46 product to Q17.16, round half up, saturate
	function automatic logic signed [OW-1:0] round_sat(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] s;
		logic signed [OW-1:0] r;
		s = (p + ROUND_HALF) >>> FRAC_TRIG;
		if (s > OUT_MAX)
			r = OW'(OUT_MAX);
		else if (s < -OUT_MAX)
			r = OW'(-OUT_MAX);
		else
			r = s[OW-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hdl/spherical_to_cartesian.sv @@
// Pipeline: ROTATION_STEPS + 4 register stages in all; the last one presents the result.
// Throughput: one transaction per cycle while the output is not stalled; one CORDIC cell
// per micro-rotation, then four multiply/round stages. Each stage holds its data while
// stalled and bubbles close up.
// Reset: clears the stage valid flags only; data registers are not reset.
`default_nettype none
module spherical_to_cartesian #(
	parameter int ROTATION_STEPS = 16
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             item_valid,
	output logic                            item_stall,
	input  wire  [s2c_pkg::RW-1:0]          radius,
	input  wire  [s2c_pkg::AW-1:0]          azimuth,
	input  wire  [s2c_pkg::AW-1:0]          elevation,
	output logic                            result_valid,
	input  wire                             result_stall,
	output logic signed [s2c_pkg::OW-1:0]   x_coord,
	output logic signed [s2c_pkg::OW-1:0]   y_coord,
	output logic signed [s2c_pkg::OW-1:0]   z_coord
);
	import s2c_pkg::*;

	localparam int NS = ROTATION_STEPS + SCALE_STAGES;

	logic [NS-1:0] v_q;
	logic [NS-1:0] ready;
	cell_data_t    chain [ROTATION_STEPS+1];

	always_comb begin
		ready[NS-1] = !v_q[NS-1] || !result_stall;
		for (int i = NS - 2; i >= 0; i--)
			ready[i] = !v_q[i] || ready[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (ready[0])
				v_q[0] <= item_valid;
			for (int i = 1; i < NS; i++)
				if (ready[i])
					v_q[i] <= v_q[i-1];
		end
	end

	assign chain[0].radius = radius;
	assign chain[0].az = rot_init(azimuth);
	assign chain[0].el = rot_init(elevation);

	for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_cell
		s2c_cell #(.STEP(g)) u_cell (
			.clk  (clk),
			.ld   (ready[g]),
			.din  (chain[g]),
			.dout (chain[g+1])
		);
	end

	s2c_scale u_scale (
		.clk     (clk),
		.ld      (ready[NS-1:ROTATION_STEPS]),
		.din     (chain[ROTATION_STEPS]),
		.x_coord (x_coord),
		.y_coord (y_coord),
		.z_coord (z_coord)
	);

	assign item_stall   = !ready[0];
	assign result_valid = v_q[NS-1];

endmodule
`default_nettype wire

@@ hdl/s2c_cell.sv @@
// One CORDIC micro-rotation stage for azimuth and elevation, radius carried along.
`default_nettype none
module s2c_cell #(
	parameter int STEP = 0
) (
	input  wire                      clk,
	input  wire                      ld,
	input  wire s2c_pkg::cell_data_t din,
	output s2c_pkg::cell_data_t      dout
);
	import s2c_pkg::*;

	localparam int K = STEP % 32;
	localparam logic signed [ZW-1:0] ATAN = atan_val(5'(K));

	cell_data_t data_q;
	cell_data_t nxt;

	function automatic rot_t rotate(input rot_t r);
		logic signed [VW-1:0] dx;
		logic signed [VW-1:0] dy;
		rot_t o;
		dx = r.y >>> K;
		dy = r.x >>> K;
		o.flip = r.flip;
		if (!r.z[ZW-1]) begin
			o.x = r.x - dx;
			o.y = r.y + dy;
			o.z = r.z - ATAN;
		end else begin
			o.x = r.x + dx;
			o.y = r.y - dy;
			o.z = r.z + ATAN;
		end
		return o;
	endfunction

	always_comb begin
		nxt.radius = din.radius;
		nxt.az = rotate(din.az);
		nxt.el = rotate(din.el);
	end

	always_ff @(posedge clk) begin
		if (ld)
			data_q <= nxt;
	end

	assign dout = data_q;

endmodule
`default_nettype wire

@@ hdl/s2c_scale.sv @@
// Quadrant sign fix, radius products, rounding and saturation over four stages.
`default_nettype none
module s2c_scale (
	input  wire                                     clk,
	input  wire  [s2c_pkg::SCALE_STAGES-1:0]        ld,
	input  wire s2c_pkg::cell_data_t                din,
	output logic signed [s2c_pkg::OW-1:0]           x_coord,
	output logic signed [s2c_pkg::OW-1:0]           y_coord,
	output logic signed [s2c_pkg::OW-1:0]           z_coord
);
	import s2c_pkg::*;

	logic signed [VW-1:0] ca, sa, ce, se, d;
	logic signed [PW-1:0] pce_s1, pse_s1;
	logic signed [VW-1:0] ca_s1, sa_s1;
	logic signed [OW-1:0] r_s2, z_s2;
	logic signed [VW-1:0] ca_s2, sa_s2;
	logic signed [PW-1:0] px_s3, py_s3;
	logic signed [OW-1:0] z_s3;
	logic signed [OW-1:0] x_s4, y_s4, z_s4;

	always_comb begin
		ca = din.az.flip ? -din.az.x : din.az.x;
		sa = din.az.flip ? -din.az.y : din.az.y;
		ce = din.el.flip ? -din.el.x : din.el.x;
		se = din.el.flip ? -din.el.y : din.el.y;
		d  = $signed({1'b0, din.radius});
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			pce_s1 <= d * ce;
			pse_s1 <= d * se;
			ca_s1  <= ca;
			sa_s1  <= sa;
		end
		if (ld[1]) begin
			r_s2  <= round_sat(pce_s1);
			z_s2  <= round_sat(pse_s1);
			ca_s2 <= ca_s1;
			sa_s2 <= sa_s1;
		end
		if (ld[2]) begin
			px_s3 <= r_s2 * ca_s2;
			py_s3 <= r_s2 * sa_s2;
			z_s3  <= z_s2;
		end
		if (ld[3]) begin
			x_s4 <= round_sat(px_s3);
			y_s4 <= round_sat(py_s3);
			z_s4 <= z_s3;
		end
	end

	assign x_coord = x_s4;
	assign y_coord = y_s4;
	assign z_coord = z_s4;

endmodule
`default_nettype wire
